[rtl/ibt_pkg.sv]
// Shared constants and types for the interval booking table.
package ibt_pkg;

   // Table size and field widths
   localparam int CAPACITY = 64;
   localparam int TIME_W   = 31;
   localparam int IN_W     = 31;
   localparam int COUNT_W  = 7;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Result codes
   typedef enum logic [1:0] {
      ST_BOOKED  = 2'd0,
      ST_OVERLAP = 2'd1,
      ST_FULL    = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_FINISH
   } state_type;

endpackage

[rtl/interval_booking_table_core.sv]
// Interval booking table: overlap check and store of half-open intervals.
//
// Request channel: drive req_start_time / req_end_time and raise start while
// busy is low; the request beat is taken on that clock edge and busy goes high.
// Each request yields exactly one response beat: rsp_valid is high for one
// cycle with rsp_status (booked, overlap, full, empty/inverted interval) and
// rsp_booking_count (bookings stored after this request).
// A request passes through the check, scan and finish states; busy is high
// in those states and start is ignored meanwhile. An empty or inverted
// interval skips the scan. One shared compare unit walks the stored
// intervals one entry per cycle through the registered read port of the slot
// memory, so the number of stored bookings sets the time a request takes.
// A new request may be taken in the same cycle the response beat is shown.
// The receiver cannot stall; it must take the response beat when shown.
// Reset (synchronous, active high) empties the table and returns to idle;
// stored intervals fill from slot 0 upward, so the fill count marks which
// slots hold data and no clearing pass is needed.
module interval_booking_table_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ibt_pkg::IN_W-1:0]      req_start_time,
   input  logic [ibt_pkg::IN_W-1:0]      req_end_time,
   output logic                          rsp_valid,
   output ibt_pkg::status_type           rsp_status,
   output logic [ibt_pkg::COUNT_W-1:0]   rsp_booking_count
);
   import ibt_pkg::*;

   // Slot memory
   logic [TIME_W-1:0] slot_start_mem [CAPACITY];
   logic [TIME_W-1:0] slot_end_mem   [CAPACITY];

   // Control registers
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              hit_ff, hit_in;
   logic              inv_ff, inv_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [TIME_W-1:0]  s_ff, s_in;
   logic [TIME_W-1:0]  e_ff, e_in;
   logic [TIME_W-1:0]  rd_start_ff, rd_end_ff;
   status_type         status_ff, status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Shared compare unit
   logic [TIME_W-1:0] cmp_lhs;
   logic              cmp_lt;
   logic              cmp_gt;
   logic              overlap;
   logic              issue;
   logic              full;
   logic              do_write;
   logic              accept;

   assign accept  = start && (state_ff == S_IDLE);
   assign cmp_lhs = (state_ff == S_CHECK) ? s_ff : rd_start_ff;
   assign cmp_lt  = cmp_lhs < e_ff;
   assign cmp_gt  = rd_end_ff > s_ff;
   assign overlap = rd_valid_ff && cmp_gt && cmp_lt;
   assign issue   = (state_ff == S_SCAN) && (idx_ff < count_ff);
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign do_write = (state_ff == S_FINISH) && !inv_ff && !hit_ff && !full;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = cmp_lt ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            if (!issue) state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath and response
   always_comb begin
      s_in         = s_ff;
      e_in         = e_ff;
      idx_in       = idx_ff;
      rd_valid_in  = 1'b0;
      hit_in       = hit_ff;
      inv_in       = inv_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               s_in   = TIME_W'(req_start_time);
               e_in   = TIME_W'(req_end_time);
               idx_in = '0;
               hit_in = 1'b0;
               inv_in = 1'b0;
            end
         end
         S_CHECK: begin
            inv_in = !cmp_lt;
         end
         S_SCAN: begin
            rd_valid_in = issue;
            if (issue) idx_in = idx_ff + CNT_W'(1);
            if (overlap) hit_in = 1'b1;
         end
         S_FINISH: begin
            rsp_valid_in = 1'b1;
            if (inv_ff) begin
               status_in = ST_EMPTY;
            end else if (hit_ff) begin
               status_in = ST_OVERLAP;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_BOOKED;
               count_in  = count_ff + CNT_W'(1);
            end
            rsp_count_in = COUNT_W'(count_in);
         end
         default: begin
            rd_valid_in = 1'b0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         inv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         inv_ff       <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      e_ff         <= e_in;
      status_ff    <= status_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         slot_start_mem[count_ff[ADDR_W-1:0]] <= s_ff;
         slot_end_mem[count_ff[ADDR_W-1:0]]   <= e_ff;
      end
      rd_start_ff <= slot_start_mem[idx_ff[ADDR_W-1:0]];
      rd_end_ff   <= slot_end_mem[idx_ff[ADDR_W-1:0]];
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_booking_count = rsp_count_ff;

   // Fill count never passes the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   // Only a booked response moves the fill count
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_BOOKED) |-> count_ff == $past(count_ff))
      else $error("refused request changed the fill count");

   // Booked response reports one more than before
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BOOKED) |->
         count_ff == $past(count_ff) + CNT_W'(1))
      else $error("booked request did not add one entry");

   // Scan reads stay within the filled part of the table
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> idx_ff <= count_ff)
      else $error("scan ran past the filled slots");

   // An accepted request keeps the block busy next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("request beat did not start a scan");

endmodule

[dv/tb_interval_booking_table_core.sv]
// Self-checking testbench for the interval booking table core.
module tb_interval_booking_table_core;
   timeunit 1ns;
   timeprecision 1ps;
   import ibt_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_REPORTS = 10;

   typedef logic [IN_W-1:0]   req_time_type;
   typedef logic [TIME_W-1:0] stamp_type;
   localparam req_time_type TIME_MAX = '1;

   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   count;
   } booking_result_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_time_type         req_start_time = '0;
   req_time_type         req_end_time = '0;
   logic                 rsp_valid;
   status_type           rsp_status;
   logic [COUNT_W-1:0]   rsp_booking_count;

   interval_booking_table_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_start_time    (req_start_time),
      .req_end_time      (req_end_time),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_booking_count (rsp_booking_count)
   );

   // Shadow copy of the booking table
   stamp_type booked_start [CAPACITY];
   stamp_type booked_end   [CAPACITY];
   bit        booked_valid [CAPACITY];
   int        booked_total;

   booking_result_type pending_results [$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  no_gaps     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // True when [s, e) overlaps any stored booking
   function automatic bit overlaps_booking(stamp_type s, stamp_type e);
      for (int i = 0; i < CAPACITY; i++)
         if (booked_valid[i] && !(booked_end[i] <= s || booked_start[i] >= e))
            return 1'b1;
      return 1'b0;
   endfunction

   // Apply one request to the shadow table and return its result
   function automatic booking_result_type book_interval(req_time_type s_in,
                                                        req_time_type e_in);
      stamp_type          s;
      stamp_type          e;
      booking_result_type res;
      int                 free_slot;
      s = stamp_type'(s_in);
      e = stamp_type'(e_in);
      free_slot = -1;
      for (int i = CAPACITY - 1; i >= 0; i--)
         if (!booked_valid[i]) free_slot = i;
      if (e <= s)
         res.status = ST_EMPTY;
      else if (overlaps_booking(s, e))
         res.status = ST_OVERLAP;
      else if (free_slot < 0)
         res.status = ST_FULL;
      else begin
         booked_start[free_slot] = s;
         booked_end[free_slot]   = e;
         booked_valid[free_slot] = 1'b1;
         booked_total++;
         res.status = ST_BOOKED;
      end
      res.count = COUNT_W'(booked_total);
      return res;
   endfunction

   function automatic req_time_type clamp_time(longint v);
      if (v < 0) return '0;
      if (v > longint'(TIME_MAX)) return TIME_MAX;
      return req_time_type'(v);
   endfunction

   // Drive one request beat; start stays high until the next gap
   task automatic send_request(req_time_type s, req_time_type e);
      int gap;
      gap = 0;
      if (!no_gaps && $urandom_range(99) < 18)
         gap = ($urandom_range(3) == 0) ? $urandom_range(70, 1) : $urandom_range(4, 1);
      if (gap > 0) begin
         if (start) start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (!start) start <= 1'b1;
      req_start_time <= s;
      req_end_time   <= e;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(book_interval(s, e));
   endtask

   // Random interval that overlaps nothing stored
   task automatic send_free_interval();
      req_time_type s;
      req_time_type e;
      do begin
         s = req_time_type'($urandom);
         e = clamp_time(longint'(s) +
                        (($urandom_range(3) == 0) ? 1 : $urandom_range(1 << 20, 1)));
      end while (e <= s || overlaps_booking(s, e));
      send_request(s, e);
   endtask

   // Interval placed against a stored booking: adjacent or overlapping
   task automatic send_near_interval();
      int           k;
      longint       w;
      longint       bs;
      longint       be;
      req_time_type s;
      req_time_type e;
      k  = $urandom_range(booked_total - 1);
      bs = longint'(booked_start[k]);
      be = longint'(booked_end[k]);
      w  = ($urandom_range(4) == 0) ? longint'($urandom_range(1 << 24, 1))
                                    : longint'($urandom_range(64, 1));
      if ($urandom_range(9) == 0) begin
         // touching but not overlapping
         if ($urandom_range(1)) begin
            s = clamp_time(be);     e = clamp_time(be + w);
         end else begin
            s = clamp_time(bs - w); e = clamp_time(bs);
         end
      end else begin
         case ($urandom_range(4))
            0: begin s = clamp_time(bs);     e = clamp_time(be);     end
            1: begin s = clamp_time(be - 1); e = clamp_time(be + w); end
            2: begin s = clamp_time(bs - w); e = clamp_time(bs + 1); end
            3: begin s = clamp_time(bs);     e = clamp_time(bs + 1); end
            default: begin s = clamp_time(bs - w); e = clamp_time(be + w); end
         endcase
      end
      send_request(s, e);
   endtask

   // Empty or inverted interval
   task automatic send_degenerate_interval();
      req_time_type s;
      s = req_time_type'($urandom);
      if ($urandom_range(1))
         send_request(s, s);
      else
         send_request(s, req_time_type'($urandom_range(32'(s))));
   endtask

   // Field extremes, empty and inverted intervals, adjacency and overlap
   task automatic test_edge_cases();
      send_request('0, '0);
      send_request(TIME_MAX, '0);
      send_request(TIME_MAX, TIME_MAX);
      send_request('0, 31'd1);
      send_request(TIME_MAX - 1, TIME_MAX);
      send_request('0, 31'd5);
      send_request(31'd1, 31'd100);
      send_request(TIME_MAX - 10, TIME_MAX - 1);
      send_request(31'd10, 31'd20);
      send_request('0, TIME_MAX);
      send_request(31'h2AAA_AAAA, 31'h5555_5555);
      send_request(31'h5555_5555, 31'h2AAA_AAAA);
      send_request(31'd99, 31'd101);
      send_request(31'd100, 31'd101);
   endtask

   // Mixed random traffic, with one stretch that never idles
   task automatic test_random_traffic(int num_items);
      int r;
      for (int i = 0; i < num_items; i++) begin
         no_gaps = (i >= num_items / 3) && (i < num_items / 2);
         r = $urandom_range(99);
         if (r < 6)
            send_free_interval();
         else if (r < 56 && booked_total > 0)
            send_near_interval();
         else if (r < 82) begin
            if ($urandom_range(1))
               send_request(req_time_type'($urandom), req_time_type'($urandom));
            else
               send_request(req_time_type'($urandom), TIME_MAX);
         end else
            send_degenerate_interval();
      end
      no_gaps = 1'b0;
   endtask

   // Fill the table, then refusals on a full table
   task automatic test_full_table();
      while (booked_total < CAPACITY)
         send_free_interval();
      send_free_interval();
      send_request(req_time_type'(booked_start[0]), req_time_type'(booked_end[0]));
      send_request('0, TIME_MAX);
      send_degenerate_interval();
      send_free_interval();
   endtask

   // Response checking
   task automatic report_error(string what, int expected, int actual);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR @%0t: %s expected %0d actual %0d", $realtime, what, expected, actual);
   endtask

   always @(posedge clock) begin
      booking_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0)
            report_error("unexpected response beat, status", -1, int'(rsp_status));
         else begin
            exp_res = pending_results.pop_front();
            if (rsp_status !== exp_res.status)
               report_error("status", int'(exp_res.status), int'(rsp_status));
            if (rsp_booking_count !== exp_res.count)
               report_error("booking_count", int'(exp_res.count), int'(rsp_booking_count));
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      for (int i = 0; i < CAPACITY; i++) booked_valid[i] = 1'b0;
      booked_total = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_cases();
      test_random_traffic(1000);
      test_full_table();
      test_random_traffic(420);

      if (start) start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
rtl/ibt_pkg.sv
rtl/interval_booking_table_core.sv
dv/tb_interval_booking_table_core.sv
